@@ sv/sadc_pkg.sv @@
// Shared constants and types for the streaming audio data coprocessor.
package sadc_pkg;

   localparam int unsigned RevisionDefault = 1;

   localparam logic [31:0] TrackMagic = 32'h4D53_5531;
   localparam logic [31:0] AudioStart = 32'd8;
   localparam logic [15:0] RegBase    = 16'h2000;

   localparam int unsigned MagWidth  = 24;
   localparam int unsigned SampWidth = 16;

   localparam logic [7:0] IdCharS    = 8'h53;
   localparam logic [7:0] IdCharDash = 8'h2D;
   localparam logic [7:0] IdCharM    = 8'h4D;
   localparam logic [7:0] IdCharU    = 8'h55;
   localparam logic [7:0] IdCharZero = 8'h30;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_STATUS = 3'd0,
      REG_DATA   = 3'd1,
      REG_DPOS2  = 3'd2,
      REG_DPOS3  = 3'd3,
      REG_TRK_LO = 3'd4,
      REG_TRK_HI = 3'd5,
      REG_VOLUME = 3'd6,
      REG_CTRL   = 3'd7
   } reg_type;

endpackage

@@ sv/sadc_scale.sv @@
// Divide an unsigned sample-volume product by 255, truncate, and apply the sign.
module sadc_scale (
   input  logic [sadc_pkg::MagWidth-1:0]         mag,
   input  logic                                  neg,
   output logic signed [sadc_pkg::SampWidth-1:0] result
);
   import sadc_pkg::*;

   logic [MagWidth:0]   est;
   logic [MagWidth-8:0] quot;
   logic [MagWidth:0]   prod;
   logic [MagWidth:0]   rem;
   logic [MagWidth-8:0] quot_fix;
   logic [MagWidth-8:0] signed_quot;

   // x/255 = x/256 + x/256^2 + ...; estimate is exact or one low
   always_comb begin
      est         = (MagWidth+1)'(mag) + (MagWidth+1)'(mag >> 8) + (MagWidth+1)'(mag >> 16);
      quot        = est[MagWidth:8];
      prod        = {quot, 8'd0} - (MagWidth+1)'(quot);
      rem         = {1'b0, mag} - prod;
      quot_fix    = (rem >= (MagWidth+1)'(255)) ? quot + (MagWidth-7)'(1) : quot;
      signed_quot = neg ? (MagWidth-7)'(0) - quot_fix : quot_fix;
      result      = signed'(signed_quot[SampWidth-1:0]);
   end

endmodule

@@ sv/streaming_audio_data_coprocessor.sv @@
// Top level of the streaming audio data coprocessor: register file, tick logic, pipeline.
//
//   port group   direction  handshake           payload
//   req_*        in         req_valid/req_stall action, bus fields, track fields, samples
//   rsp_*        out        rsp_valid/rsp_stall read byte, scaled samples, offsets, flags
//   csr_*        in         csr_wr_en           data_file_present
//
// One transfer per cycle while rsp_stall is low; path: input register, then result register.
// The first stage multiplies |sample| by volume, the second divides by 255 and updates state.
// Synchronous active-high reset restores the register file defaults.
// rsp_stall holds the result register; req_stall rises only when both stages are full.
module streaming_audio_data_coprocessor #(
   parameter int unsigned REVISION = sadc_pkg::RevisionDefault
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                csr_wr_en,
   input  logic                csr_wr_data,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [15:0]         req_bus_addr,
   input  logic [7:0]          req_write_data,
   input  logic [7:0]          req_data_byte,
   input  logic                req_track_found,
   input  logic [31:0]         req_track_header,
   input  logic [31:0]         req_loop_index,
   input  logic                req_at_end,
   input  logic signed [15:0]  req_sample_left,
   input  logic signed [15:0]  req_sample_right,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_read_data,
   output logic signed [15:0]  rsp_out_left,
   output logic signed [15:0]  rsp_out_right,
   output logic [31:0]         rsp_data_offset_now,
   output logic [31:0]         rsp_audio_offset_now,
   output logic [15:0]         rsp_track_now,
   output logic                rsp_data_consumed,
   output logic                rsp_playing
);
   import sadc_pkg::*;

   localparam logic [3:0] RevNibble = 4'(REVISION);
   localparam logic [7:0] RevChar   = IdCharZero + 8'(REVISION);

   // control and state
   logic        file_present_ff;
   logic        s1_valid_ff, s1_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] data_pos_ff, data_pos_in;
   logic [31:0] audio_pos_ff, audio_pos_in;
   logic [31:0] loop_pos_ff, loop_pos_in;
   logic [15:0] track_sel_ff, track_sel_in;
   logic [7:0]  volume_ff, volume_in;
   logic        data_busy_ff, data_busy_in;
   logic        audio_busy_ff, audio_busy_in;
   logic        repeat_ff, repeat_in;
   logic        play_ff, play_in;
   logic        track_open_ff, track_open_in;

   // stage 1 payload
   action_type           s1_action_ff;
   logic [15:0]          s1_addr_ff;
   logic [7:0]           s1_wdata_ff;
   logic [7:0]           s1_dbyte_ff;
   logic                 s1_found_ff;
   logic [31:0]          s1_header_ff;
   logic [31:0]          s1_loop_ff;
   logic                 s1_at_end_ff;
   logic [MagWidth-1:0]  s1_mag_l_ff, s1_mag_r_ff;
   logic                 s1_neg_l_ff, s1_neg_r_ff;

   // result payload
   logic [7:0]           rsp_read_data_ff, rsp_read_data_in;
   logic signed [15:0]   rsp_left_ff, rsp_right_ff;
   logic [31:0]          rsp_dpos_ff, rsp_apos_ff;
   logic [15:0]          rsp_track_ff;
   logic                 rsp_consumed_ff, rsp_consumed_in;
   logic                 rsp_playing_ff;

   logic                 out_free, advance, accept;
   logic                 is_reg, samp_en;
   reg_type              reg_sel;
   logic [7:0]           vol_eff;
   logic [15:0]          abs_l, abs_r;
   logic signed [15:0]   scaled_l, scaled_r;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !out_free);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign is_reg  = s1_addr_ff[15:3] == RegBase[15:3];
   assign reg_sel = reg_type'(s1_addr_ff[2:0]);

   always_comb begin
      data_pos_in      = data_pos_ff;
      audio_pos_in     = audio_pos_ff;
      loop_pos_in      = loop_pos_ff;
      track_sel_in     = track_sel_ff;
      volume_in        = volume_ff;
      data_busy_in     = data_busy_ff;
      audio_busy_in    = audio_busy_ff;
      repeat_in        = repeat_ff;
      play_in          = play_ff;
      track_open_in    = track_open_ff;
      rsp_read_data_in = 8'd0;
      rsp_consumed_in  = 1'b0;
      samp_en          = 1'b0;
      case (s1_action_ff)
         ACT_READ: begin
            if (is_reg) begin
               case (reg_sel)
                  REG_STATUS: rsp_read_data_in = {data_busy_ff, audio_busy_ff, repeat_ff,
                                                  play_ff, RevNibble};
                  REG_DATA: begin
                     if (!data_busy_ff) begin
                        data_pos_in      = data_pos_ff + 32'd1;
                        rsp_consumed_in  = 1'b1;
                        rsp_read_data_in = file_present_ff ? s1_dbyte_ff : 8'd0;
                     end
                  end
                  REG_DPOS2:  rsp_read_data_in = IdCharS;
                  REG_DPOS3:  rsp_read_data_in = IdCharDash;
                  REG_TRK_LO: rsp_read_data_in = IdCharM;
                  REG_TRK_HI: rsp_read_data_in = IdCharS;
                  REG_VOLUME: rsp_read_data_in = IdCharU;
                  REG_CTRL:   rsp_read_data_in = RevChar;
                  default:    rsp_read_data_in = 8'd0;
               endcase
            end
         end
         ACT_WRITE: begin
            if (is_reg) begin
               case (reg_sel)
                  REG_STATUS: data_pos_in[7:0]   = s1_wdata_ff;
                  REG_DATA:   data_pos_in[15:8]  = s1_wdata_ff;
                  REG_DPOS2:  data_pos_in[23:16] = s1_wdata_ff;
                  REG_DPOS3: begin
                     data_pos_in[31:24] = s1_wdata_ff;
                     data_busy_in       = 1'b0;
                  end
                  REG_TRK_LO: track_sel_in[7:0] = s1_wdata_ff;
                  REG_TRK_HI: begin
                     track_sel_in[15:8] = s1_wdata_ff;
                     track_open_in      = s1_found_ff && (s1_header_ff == TrackMagic);
                     if (track_open_in) begin
                        audio_pos_in = AudioStart;
                        loop_pos_in  = AudioStart + {s1_loop_ff[29:0], 2'b00};
                     end
                     audio_busy_in = 1'b0;
                     repeat_in     = 1'b0;
                     play_in       = 1'b0;
                  end
                  REG_VOLUME: volume_in = s1_wdata_ff;
                  REG_CTRL: begin
                     repeat_in = s1_wdata_ff[1];
                     play_in   = s1_wdata_ff[0];
                  end
                  default: ;
               endcase
            end
         end
         ACT_TICK: begin
            if (play_ff) begin
               if (!track_open_ff) begin
                  play_in = 1'b0;
               end else if (s1_at_end_ff) begin
                  if (!repeat_ff) begin
                     play_in      = 1'b0;
                     audio_pos_in = AudioStart;
                  end else begin
                     audio_pos_in = loop_pos_ff;
                  end
               end else begin
                  audio_pos_in = audio_pos_ff + 32'd4;
                  samp_en      = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // volume written by the item leaving stage 1 applies to the item entering it
   assign vol_eff = advance ? volume_in : volume_ff;
   assign abs_l   = req_sample_left[15]  ? 16'd0 - 16'(req_sample_left)  : 16'(req_sample_left);
   assign abs_r   = req_sample_right[15] ? 16'd0 - 16'(req_sample_right) : 16'(req_sample_right);

   sadc_scale u_scale_l (
      .mag    (s1_mag_l_ff),
      .neg    (s1_neg_l_ff),
      .result (scaled_l)
   );

   sadc_scale u_scale_r (
      .mag    (s1_mag_r_ff),
      .neg    (s1_neg_r_ff),
      .result (scaled_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         file_present_ff <= 1'b0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         data_pos_ff     <= 32'd0;
         audio_pos_ff    <= 32'd0;
         loop_pos_ff     <= 32'd0;
         track_sel_ff    <= 16'd0;
         volume_ff       <= 8'd255;
         data_busy_ff    <= 1'b1;
         audio_busy_ff   <= 1'b1;
         repeat_ff       <= 1'b0;
         play_ff         <= 1'b0;
         track_open_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            file_present_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            data_pos_ff   <= data_pos_in;
            audio_pos_ff  <= audio_pos_in;
            loop_pos_ff   <= loop_pos_in;
            track_sel_ff  <= track_sel_in;
            volume_ff     <= volume_in;
            data_busy_ff  <= data_busy_in;
            audio_busy_ff <= audio_busy_in;
            repeat_ff     <= repeat_in;
            play_ff       <= play_in;
            track_open_ff <= track_open_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= action_type'(req_action);
         s1_addr_ff   <= req_bus_addr;
         s1_wdata_ff  <= req_write_data;
         s1_dbyte_ff  <= req_data_byte;
         s1_found_ff  <= req_track_found;
         s1_header_ff <= req_track_header;
         s1_loop_ff   <= req_loop_index;
         s1_at_end_ff <= req_at_end;
         s1_mag_l_ff  <= MagWidth'(abs_l) * MagWidth'(vol_eff);
         s1_mag_r_ff  <= MagWidth'(abs_r) * MagWidth'(vol_eff);
         s1_neg_l_ff  <= req_sample_left[15];
         s1_neg_r_ff  <= req_sample_right[15];
      end
      if (advance) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_left_ff      <= samp_en ? scaled_l : 16'sd0;
         rsp_right_ff     <= samp_en ? scaled_r : 16'sd0;
         rsp_dpos_ff      <= data_pos_in;
         rsp_apos_ff      <= audio_pos_in;
         rsp_track_ff     <= track_sel_in;
         rsp_consumed_ff  <= rsp_consumed_in;
         rsp_playing_ff   <= play_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_read_data        = rsp_read_data_ff;
   assign rsp_out_left         = rsp_left_ff;
   assign rsp_out_right        = rsp_right_ff;
   assign rsp_data_offset_now  = rsp_dpos_ff;
   assign rsp_audio_offset_now = rsp_apos_ff;
   assign rsp_track_now        = rsp_track_ff;
   assign rsp_data_consumed    = rsp_consumed_ff;
   assign rsp_playing          = rsp_playing_ff;

endmodule

@@ tb/sadc_checker.sv @@
// Checker for the streaming audio data coprocessor: predicts each result and compares it.
`timescale 1ns / 1ps

module sadc_checker #(
   parameter int unsigned REVISION = sadc_pkg::RevisionDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [15:0]         req_bus_addr,
   input  logic [7:0]          req_write_data,
   input  logic [7:0]          req_data_byte,
   input  logic                req_track_found,
   input  logic [31:0]         req_track_header,
   input  logic [31:0]         req_loop_index,
   input  logic                req_at_end,
   input  logic signed [15:0]  req_sample_left,
   input  logic signed [15:0]  req_sample_right,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [7:0]          rsp_read_data,
   input  logic signed [15:0]  rsp_out_left,
   input  logic signed [15:0]  rsp_out_right,
   input  logic [31:0]         rsp_data_offset_now,
   input  logic [31:0]         rsp_audio_offset_now,
   input  logic [15:0]         rsp_track_now,
   input  logic                rsp_data_consumed,
   input  logic                rsp_playing,
   output int                  errors,
   output int                  pending
);
   import sadc_pkg::*;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [15:0] left;
      logic [15:0] right;
      logic [31:0] data_off;
      logic [31:0] audio_off;
      logic [15:0] track;
      logic        consumed;
      logic        playing;
   } sadc_result_type;

   logic [31:0] data_ptr, audio_ptr, loop_ptr;
   logic [15:0] track_num;
   logic [7:0]  vol_level;
   logic        data_locked, audio_locked, repeat_on, play_on, track_ready, file_present;

   sadc_result_type expected_results[$];

   function automatic void reset_predictor();
      data_ptr     = '0;
      audio_ptr    = '0;
      loop_ptr     = '0;
      track_num    = '0;
      vol_level    = 8'd255;
      data_locked  = 1'b1;
      audio_locked = 1'b1;
      repeat_on    = 1'b0;
      play_on      = 1'b0;
      track_ready  = 1'b0;
      file_present = 1'b0;
   endfunction

   // truncates toward zero, as integer division does
   function automatic logic [15:0] apply_volume(logic signed [15:0] s);
      int prod;
      prod = int'(s) * int'({24'd0, vol_level});
      return 16'(prod / 255);
   endfunction

   function automatic sadc_result_type predict_result();
      sadc_result_type res;
      reg_type         r;
      logic            mapped;
      res = '0;
      mapped = (req_bus_addr[15:3] == RegBase[15:3]);
      r = reg_type'(req_bus_addr[2:0]);
      case (action_type'(req_action))
         ACT_READ: if (mapped) begin
            case (r)
               REG_STATUS: res.read_data = {data_locked, audio_locked, repeat_on, play_on,
                                            4'(REVISION)};
               REG_DATA: if (!data_locked) begin
                  data_ptr = data_ptr + 32'd1;
                  res.consumed = 1'b1;
                  res.read_data = file_present ? req_data_byte : 8'd0;
               end
               REG_DPOS2, REG_TRK_HI: res.read_data = IdCharS;
               REG_DPOS3:  res.read_data = IdCharDash;
               REG_TRK_LO: res.read_data = IdCharM;
               REG_VOLUME: res.read_data = IdCharU;
               REG_CTRL:   res.read_data = IdCharZero + 8'(REVISION);
               default: ;
            endcase
         end
         ACT_WRITE: if (mapped) begin
            case (r)
               REG_STATUS: data_ptr[7:0] = req_write_data;
               REG_DATA:   data_ptr[15:8] = req_write_data;
               REG_DPOS2:  data_ptr[23:16] = req_write_data;
               REG_DPOS3: begin
                  data_ptr[31:24] = req_write_data;
                  data_locked = 1'b0;
               end
               REG_TRK_LO: track_num[7:0] = req_write_data;
               REG_TRK_HI: begin
                  track_num[15:8] = req_write_data;
                  track_ready = req_track_found && (req_track_header == TrackMagic);
                  if (track_ready) begin
                     audio_ptr = AudioStart;
                     loop_ptr = AudioStart + {req_loop_index[29:0], 2'b00};
                  end
                  audio_locked = 1'b0;
                  repeat_on = 1'b0;
                  play_on = 1'b0;
               end
               REG_VOLUME: vol_level = req_write_data;
               REG_CTRL: begin
                  repeat_on = req_write_data[1];
                  play_on = req_write_data[0];
               end
               default: ;
            endcase
         end
         ACT_TICK: if (play_on) begin
            if (!track_ready) begin
               play_on = 1'b0;
            end else if (req_at_end) begin
               if (!repeat_on) begin
                  play_on = 1'b0;
                  audio_ptr = AudioStart;
               end else begin
                  audio_ptr = loop_ptr;
               end
            end else begin
               audio_ptr = audio_ptr + 32'd4;
               res.left = apply_volume(req_sample_left);
               res.right = apply_volume(req_sample_right);
            end
         end
         default: ;
      endcase
      res.data_off = data_ptr;
      res.audio_off = audio_ptr;
      res.track = track_num;
      res.playing = play_on;
      return res;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin : monitor
      sadc_result_type want, got;
      if (reset) begin
         reset_predictor();
         expected_results.delete();
      end else begin
         if (csr_wr_en)
            file_present = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_read_data, rsp_out_left, rsp_out_right, rsp_data_offset_now,
                   rsp_audio_offset_now, rsp_track_now, rsp_data_consumed, rsp_playing};
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: result transfer with nothing expected, actual %0h", $time, got);
            end else begin
               want = expected_results.pop_front();
               compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
               compare_field("out_left", 32'(want.left), 32'(got.left));
               compare_field("out_right", 32'(want.right), 32'(got.right));
               compare_field("data_offset_now", want.data_off, got.data_off);
               compare_field("audio_offset_now", want.audio_off, got.audio_off);
               compare_field("track_now", 32'(want.track), 32'(got.track));
               compare_field("data_consumed", 32'(want.consumed), 32'(got.consumed));
               compare_field("playing", 32'(want.playing), 32'(got.playing));
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(predict_result());
      end
      pending = expected_results.size();
   end

endmodule

@@ tb/tb.sv @@
// Testbench top for the streaming audio data coprocessor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
   import sadc_pkg::*;

   typedef struct {
      action_type         act;
      logic [15:0]        addr;
      logic [7:0]         wdata;
      logic [7:0]         dbyte;
      logic               found;
      logic [31:0]        header;
      logic [31:0]        loop_idx;
      logic               at_end;
      logic signed [15:0] left;
      logic signed [15:0] right;
   } bus_item_type;

   localparam int ItemsTotal    = 1850;
   localparam int NumPhases     = 6;
   localparam int HoldOffCycles = 300;
   localparam int WatchdogLimit = 5000;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic                csr_wr_data;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_action;
   logic [15:0]         req_bus_addr;
   logic [7:0]          req_write_data;
   logic [7:0]          req_data_byte;
   logic                req_track_found;
   logic [31:0]         req_track_header;
   logic [31:0]         req_loop_index;
   logic                req_at_end;
   logic signed [15:0]  req_sample_left;
   logic signed [15:0]  req_sample_right;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [7:0]          rsp_read_data;
   logic signed [15:0]  rsp_out_left;
   logic signed [15:0]  rsp_out_right;
   logic [31:0]         rsp_data_offset_now;
   logic [31:0]         rsp_audio_offset_now;
   logic [15:0]         rsp_track_now;
   logic                rsp_data_consumed;
   logic                rsp_playing;
   int                  errors;
   int                  pending;

   int   idle_pct = 22;
   int   stall_pct = 22;
   int   items_sent = 0;
   int   quiet_cycles = 0;
   logic hold_off_go = 1'b0;

   streaming_audio_data_coprocessor u_top (.*);
   sadc_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // receiver side: random stalls, plus one long hold-off on request
   initial begin : receiver
      int held;
      held = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            held = HoldOffCycles;
         end
         if (held > 0) begin
            rsp_stall <= 1'b1;
            held--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("FAIL streaming_audio_data_coprocessor");
         $finish;
      end
   end

   function automatic bus_item_type base_item(action_type a, reg_type r);
      bus_item_type it;
      it.act = a;
      it.addr = RegBase + 16'(r);
      it.wdata = 8'($urandom);
      it.dbyte = 8'($urandom);
      it.found = 1'($urandom);
      it.header = $urandom();
      it.loop_idx = $urandom();
      it.at_end = 1'($urandom);
      it.left = 16'($urandom);
      it.right = 16'($urandom);
      return it;
   endfunction

   task automatic send(input bus_item_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= it.act;
      req_bus_addr <= it.addr;
      req_write_data <= it.wdata;
      req_data_byte <= it.dbyte;
      req_track_found <= it.found;
      req_track_header <= it.header;
      req_loop_index <= it.loop_idx;
      req_at_end <= it.at_end;
      req_sample_left <= it.left;
      req_sample_right <= it.right;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic bus_wr(reg_type r, logic [7:0] d);
      bus_item_type it;
      it = base_item(ACT_WRITE, r);
      it.wdata = d;
      send(it);
   endtask

   task automatic bus_rd(reg_type r);
      send(base_item(ACT_READ, r));
   endtask

   task automatic open_track(logic [7:0] hi, logic found, logic [31:0] hdr, logic [31:0] li);
      bus_item_type it;
      it = base_item(ACT_WRITE, REG_TRK_HI);
      it.wdata = hi;
      it.found = found;
      it.header = hdr;
      it.loop_idx = li;
      send(it);
   endtask

   task automatic tick(logic at_end, logic signed [15:0] l, logic signed [15:0] r);
      bus_item_type it;
      it = base_item(ACT_TICK, REG_STATUS);
      it.at_end = at_end;
      it.left = l;
      it.right = r;
      send(it);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_file_present(logic v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic play_sequence();
      bus_item_type it;
      int n;
      if ($urandom_range(3) != 0) begin
         bus_wr(REG_TRK_LO, 8'($urandom));
         it = base_item(ACT_WRITE, REG_TRK_HI);
         it.found = ($urandom_range(9) != 0);
         if ($urandom_range(9) != 0) it.header = TrackMagic;
         if ($urandom_range(3) != 0) it.loop_idx = $urandom_range(4095);
         send(it);
      end
      if ($urandom_range(2) == 0) begin
         case ($urandom_range(3))
            0: bus_wr(REG_VOLUME, 8'd0);
            1: bus_wr(REG_VOLUME, 8'd255);
            default: bus_wr(REG_VOLUME, 8'($urandom));
         endcase
      end
      it = base_item(ACT_WRITE, REG_CTRL);
      if ($urandom_range(6) != 0) it.wdata[0] = 1'b1;
      send(it);
      n = $urandom_range(4, 24);
      repeat (n) begin
         case ($urandom_range(19))
            0: bus_rd(REG_STATUS);
            1: bus_wr(REG_CTRL, 8'($urandom) | 8'h01);
            default: begin
               it = base_item(ACT_TICK, reg_type'($urandom_range(7)));
               it.at_end = ($urandom_range(11) == 0);
               case ($urandom_range(15))
                  0: it.left = 16'h8000;
                  1: it.left = 16'h7FFF;
                  2: it.right = 16'h8000;
                  3: it.right = 16'h7FFF;
                  default: ;
               endcase
               send(it);
            end
         endcase
      end
   endtask

   task automatic data_sequence();
      int n;
      if ($urandom_range(4) != 0) begin
         for (int k = 0; k < 4; k++)
            bus_wr(reg_type'(k), ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom));
      end else begin
         bus_wr(reg_type'($urandom_range(3)), 8'($urandom));
      end
      n = $urandom_range(2, 12);
      repeat (n) begin
         if ($urandom_range(7) == 0)
            bus_rd(REG_STATUS);
         else
            bus_rd(REG_DATA);
      end
   endtask

   task automatic noise_sequence();
      bus_item_type it;
      repeat ($urandom_range(1, 3)) begin
         it = base_item(action_type'($urandom_range(3)), reg_type'($urandom_range(7)));
         if ($urandom_range(1) == 0) it.addr = 16'($urandom);
         send(it);
      end
   endtask

   initial begin : stimulus
      bus_item_type it;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_valid = 1'b0;
      req_action = '0;
      req_bus_addr = '0;
      req_write_data = '0;
      req_data_byte = '0;
      req_track_found = 1'b0;
      req_track_header = '0;
      req_loop_index = '0;
      req_at_end = 1'b0;
      req_sample_left = '0;
      req_sample_right = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_file_present(1'b0);

      // directed: status and ID, busy data port, offset wrap, track open, loop, stop
      bus_rd(REG_STATUS);
      bus_rd(REG_DATA);
      for (int k = 2; k < 8; k++) bus_rd(reg_type'(k));
      it = base_item(ACT_READ, REG_STATUS);
      it.addr = 16'hFFFF;
      send(it);
      it = base_item(ACT_WRITE, REG_STATUS);
      it.addr = 16'h0000;
      send(it);
      for (int k = 0; k < 4; k++) bus_wr(reg_type'(k), 8'hFF);
      bus_rd(REG_DATA);
      bus_wr(REG_TRK_LO, 8'hFF);
      open_track(8'hFF, 1'b1, TrackMagic, 32'h3FFF_FFFD);
      bus_wr(REG_CTRL, 8'h03);
      tick(1'b0, 16'sh8000, 16'sh7FFF);
      tick(1'b1, 16'sh0001, -16'sh0001);
      tick(1'b0, 16'sh7FFF, 16'sh8000);
      bus_wr(REG_VOLUME, 8'h00);
      tick(1'b0, 16'sh8000, -16'sh0001);
      bus_wr(REG_CTRL, 8'h01);
      tick(1'b1, 16'sh1234, 16'sh4321);
      tick(1'b0, 16'sh1234, 16'sh4321);
      open_track(8'h00, 1'b1, 32'h4D53_5530, 32'h0);
      bus_wr(REG_CTRL, 8'h01);
      tick(1'b0, 16'sh1234, 16'sh4321);
      send(base_item(ACT_NONE, REG_STATUS));

      for (int phase = 0; phase < NumPhases; phase++) begin
         wait_drained();
         write_file_present(phase % 2 == 0);
         idle_pct = (phase == 1 || phase == 3) ? 0 : 22;
         stall_pct = (phase == 1) ? 0 : 22;
         if (phase == 3) hold_off_go = 1'b1;
         while (items_sent < (phase + 1) * ItemsTotal / NumPhases) begin
            case ($urandom_range(9))
               0, 1, 2, 3: play_sequence();
               4, 5, 6: data_sequence();
               7: for (int k = 0; k < 8; k++) bus_rd(reg_type'(k));
               default: noise_sequence();
            endcase
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("PASS streaming_audio_data_coprocessor");
      else
         $display("FAIL streaming_audio_data_coprocessor");
      $finish;
   end

endmodule
